FILE: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: implication");
`define ASSERT_DELAY(label, clk, rst, lhs, n, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> ##n (rhs)) \
      else $error("assertion failed: delayed implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define ASSERT_DELAY(label, clk, rst, lhs, n, rhs)
`endif
`endif

FILE: design/cbyp_pkg.sv
// Shared constants, types and divisor tables for the camera basis pipeline.
package cbyp_pkg;
   localparam int IN_W = 17;
   localparam logic [63:0] DEG2RAD_Q40 = 64'd19190098069;
   localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;
   localparam int SIN_STEPS = 6;
   localparam int COS_STEPS = 7;
   localparam int STEP_LAT = 3;
   localparam int SIDE_LEN = COS_STEPS * STEP_LAT + 1;
   localparam int SC_LAT = 5 + COS_STEPS * STEP_LAT + 1;
   localparam int BASIS_LAT = 3;

   typedef struct packed {
      logic [31:0] r;
      logic        swap;
      logic [1:0]  quad;
   } side_type;

   // signed Q31 sine and cosine of one angle
   typedef struct packed {
      logic signed [32:0] sn;
      logic signed [32:0] cs;
   } trig_type;

   function automatic int sin_div(input int i);
      int d;
      case (i)
         0: d = 156;
         1: d = 110;
         2: d = 72;
         3: d = 42;
         4: d = 20;
         default: d = 6;
      endcase
      return d;
   endfunction

   function automatic int cos_div(input int i);
      int d;
      case (i)
         0: d = 182;
         1: d = 132;
         2: d = 90;
         3: d = 56;
         4: d = 30;
         5: d = 12;
         default: d = 2;
      endcase
      return d;
   endfunction
endpackage

FILE: design/cbyp_step.sv
// One Horner step t' = 1 - round(r2*t)/DIV in Q32, three register stages.
module cbyp_step #(
   parameter int DIV = 2
) (
   input  logic        clock,
   input  logic [31:0] r2_i,
   input  logic [32:0] t_i,
   output logic [31:0] r2_o,
   output logic [32:0] t_o
);
   localparam logic [32:0] MAGIC = 33'((64'd1 << 33) / DIV);

   logic [31:0] pa_ff, pa_in, r2a_ff;
   logic [31:0] pb_ff, q0_ff, q0_in, r2b_ff;
   logic [32:0] t_ff, t_in;
   logic [31:0] r2c_ff;
   logic [64:0] prod_a, prod_b;
   logic [40:0] rem;
   logic [31:0] q;

   always_comb begin
      prod_a = 65'({33'b0, r2_i} * {32'b0, t_i}) + 65'(64'd1 << 31);
      pa_in  = prod_a[63:32];
      prod_b = {33'b0, pa_ff} * {32'b0, MAGIC};
      q0_in  = prod_b[64:33];
      // estimate is low by at most one
      rem    = 41'(pb_ff) - 41'(q0_ff) * 41'(DIV);
      q      = (rem >= 41'(DIV)) ? q0_ff + 32'd1 : q0_ff;
      t_in   = cbyp_pkg::Q32_ONE - {1'b0, q};
   end

   always_ff @(posedge clock) begin
      pa_ff  <= pa_in;
      r2a_ff <= r2_i;
      pb_ff  <= pa_ff;
      q0_ff  <= q0_in;
      r2b_ff <= r2a_ff;
      t_ff   <= t_in;
      r2c_ff <= r2b_ff;
   end

   assign r2_o = r2c_ff;
   assign t_o  = t_ff;
endmodule

FILE: design/cbyp_sincos.sv
// Angle reduction, octant folding and sin/cos series pipeline for one angle.
module cbyp_sincos #(
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic                               clock,
   input  logic signed [cbyp_pkg::IN_W-1:0]   angle,
   output cbyp_pkg::trig_type                 trig
);
   localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
   localparam int FULL = 4 * QUARTER;
   localparam int EIGHTH = 45 << ANGLE_FRAC_BITS;
   localparam int AMW = $clog2(FULL);
   localparam int QW = $clog2(EIGHTH + 1);
   localparam logic [16:0] MF = 17'((64'd1 << 17) / FULL);
   localparam int REM_C = (1 << 16) % FULL;
   localparam int NS = cbyp_pkg::SIN_STEPS;
   localparam int NC = cbyp_pkg::COS_STEPS;
   localparam int SL = cbyp_pkg::SIDE_LEN;

   logic [16:0] u1_ff, u1_in, q01_ff, q01_in;
   logic [AMW-1:0] a2_ff, a2_in;
   logic [QW-1:0] rem3_ff, rem3_in;
   logic swap3_ff, swap3_in, swap4_ff;
   logic [1:0] quad3_ff, quad3_in, quad4_ff;
   logic [31:0] r4_ff, r4_in, r2_ff, r2_in;
   cbyp_pkg::side_type side_ff [SL];
   logic [33:0] prod1;
   logic [39:0] t1, m2, a3, remq;
   logic [63:0] prod4, prod5;

   logic [31:0] sr2 [NS+1];
   logic [32:0] st [NS+1];
   logic [31:0] cr2 [NC+1];
   logic [32:0] ct [NC+1];
   logic [32:0] sn_ff [3];
   logic [64:0] prod_s;
   logic [32:0] s0, c0;
   logic [33:0] s1w, c1w;
   logic signed [32:0] s1, c1;
   cbyp_pkg::trig_type trig_ff, trig_in;

   always_comb begin
      // offset to unsigned, then reduce by reciprocal with one correction
      u1_in  = {~angle[16], angle[15:0]};
      prod1  = {17'b0, u1_in} * {17'b0, MF};
      q01_in = prod1[33:17];
      t1 = 40'(u1_ff) - 40'(q01_ff) * 40'(FULL);
      if (t1 >= 40'(FULL)) t1 = t1 - 40'(FULL);
      m2 = t1 - 40'(REM_C);
      if (m2[39]) m2 = m2 + 40'(FULL);
      a2_in = m2[AMW-1:0];
      a3 = 40'(a2_ff);
      if (a3 >= 40'(3 * QUARTER)) quad3_in = 2'd3;
      else if (a3 >= 40'(2 * QUARTER)) quad3_in = 2'd2;
      else if (a3 >= 40'(QUARTER)) quad3_in = 2'd1;
      else quad3_in = 2'd0;
      remq = a3 - 40'(quad3_in) * 40'(QUARTER);
      swap3_in = remq > 40'(EIGHTH);
      if (swap3_in) remq = 40'(QUARTER) - remq;
      rem3_in = remq[QW-1:0];
      prod4 = 64'(rem3_ff) * cbyp_pkg::DEG2RAD_Q40 + (64'd1 << (ANGLE_FRAC_BITS + 7));
      r4_in = 32'(prod4 >> (ANGLE_FRAC_BITS + 8));
      prod5 = 64'(r4_ff) * 64'(r4_ff) + (64'd1 << 31);
      r2_in = prod5[63:32];
   end

   always_ff @(posedge clock) begin
      u1_ff    <= u1_in;
      q01_ff   <= q01_in;
      a2_ff    <= a2_in;
      rem3_ff  <= rem3_in;
      swap3_ff <= swap3_in;
      quad3_ff <= quad3_in;
      r4_ff    <= r4_in;
      swap4_ff <= swap3_ff;
      quad4_ff <= quad3_ff;
      r2_ff    <= r2_in;
      side_ff[0] <= '{r: r4_ff, swap: swap4_ff, quad: quad4_ff};
      for (int k = 1; k < SL; k++) side_ff[k] <= side_ff[k-1];
   end

   assign sr2[0] = r2_ff;
   assign st[0]  = cbyp_pkg::Q32_ONE;
   assign cr2[0] = r2_ff;
   assign ct[0]  = cbyp_pkg::Q32_ONE;

   for (genvar g = 0; g < NS; g++) begin : g_sin
      cbyp_step #(.DIV(cbyp_pkg::sin_div(g))) u_step (
         .clock(clock), .r2_i(sr2[g]), .t_i(st[g]), .r2_o(sr2[g+1]), .t_o(st[g+1])
      );
   end

   for (genvar g = 0; g < NC; g++) begin : g_cos
      cbyp_step #(.DIV(cbyp_pkg::cos_div(g))) u_step (
         .clock(clock), .r2_i(cr2[g]), .t_i(ct[g]), .r2_o(cr2[g+1]), .t_o(ct[g+1])
      );
   end

   always_comb begin
      prod_s = 65'({33'b0, side_ff[NS*cbyp_pkg::STEP_LAT].r} * {32'b0, st[NS]})
               + 65'(64'd1 << 31);
      s0 = side_ff[SL-1].swap ? ct[NC] : sn_ff[2];
      c0 = side_ff[SL-1].swap ? sn_ff[2] : ct[NC];
      s1w = ({1'b0, s0} + 34'd1) >> 1;
      c1w = ({1'b0, c0} + 34'd1) >> 1;
      s1 = signed'(s1w[32:0]);
      c1 = signed'(c1w[32:0]);
      case (side_ff[SL-1].quad)
         2'd0: trig_in = '{sn: s1, cs: c1};
         2'd1: trig_in = '{sn: c1, cs: -s1};
         2'd2: trig_in = '{sn: -s1, cs: -c1};
         default: trig_in = '{sn: -c1, cs: s1};
      endcase
   end

   always_ff @(posedge clock) begin
      sn_ff[0] <= {1'b0, prod_s[63:32]};
      sn_ff[1] <= sn_ff[0];
      sn_ff[2] <= sn_ff[1];
      trig_ff  <= trig_in;
   end

   assign trig = trig_ff;
endmodule

FILE: design/cbyp_basis.sv
// Products, sign of cos pitch, rounding and saturation of the basis vectors.
module cbyp_basis #(
   parameter int OUT_FRAC_BITS = 15
) (
   input  logic                       clock,
   input  cbyp_pkg::trig_type         yaw,
   input  cbyp_pkg::trig_type         pitch,
   output logic signed [OUT_FRAC_BITS:0] front_x,
   output logic signed [OUT_FRAC_BITS:0] front_y,
   output logic signed [OUT_FRAC_BITS:0] front_z,
   output logic signed [OUT_FRAC_BITS:0] right_x,
   output logic signed [OUT_FRAC_BITS:0] right_y,
   output logic signed [OUT_FRAC_BITS:0] right_z,
   output logic signed [OUT_FRAC_BITS:0] up_x,
   output logic signed [OUT_FRAC_BITS:0] up_y,
   output logic signed [OUT_FRAC_BITS:0] up_z,
   output logic                       degenerate
);
   localparam int OW = OUT_FRAC_BITS + 1;
   localparam int S31 = 31 - OUT_FRAC_BITS;
   localparam int S62 = 62 - OUT_FRAC_BITS;

   typedef logic signed [OW-1:0] out_type;

   function automatic out_type round_sat(input logic signed [65:0] v, input int sh);
      logic [65:0] m;
      logic [65:0] lim;
      out_type res;
      m = v[65] ? 66'(-v) : 66'(v);
      m = (m + (66'd1 << (sh - 1))) >> sh;
      lim = 66'd1 << OUT_FRAC_BITS;
      if (v[65]) begin
         if (m > lim) m = lim;
         res = OW'(-m);
      end else begin
         if (m > lim - 66'd1) m = lim - 66'd1;
         res = OW'(m);
      end
      return res;
   endfunction

   function automatic logic signed [65:0] ext(input logic signed [33:0] x);
      return {{32{x[33]}}, x};
   endfunction

   logic signed [65:0] pcc_ff, psc_ff, pcs_ff, pss_ff;
   logic signed [32:0] sy1_ff, cy1_ff, sp1_ff, cp1_ff;
   logic signed [65:0] fx2_ff, fz2_ff, ux2_ff, uz2_ff;
   logic signed [33:0] fy2_ff, rx2_ff, rz2_ff, uy2_ff, cp2_ff;
   logic neg;
   out_type fx_ff, fy_ff, fz_ff, rx_ff, rz_ff, ux_ff, uy_ff, uz_ff;
   logic deg_ff, deg_in;

   always_ff @(posedge clock) begin
      pcc_ff <= 66'(yaw.cs * pitch.cs);
      psc_ff <= 66'(yaw.sn * pitch.cs);
      pcs_ff <= 66'(yaw.cs * pitch.sn);
      pss_ff <= 66'(yaw.sn * pitch.sn);
      sy1_ff <= yaw.sn;
      cy1_ff <= yaw.cs;
      sp1_ff <= pitch.sn;
      cp1_ff <= pitch.cs;
   end

   assign neg = cp1_ff[32];

   // sign of cos pitch folded into right and up before rounding
   always_ff @(posedge clock) begin
      fx2_ff <= pcc_ff;
      fz2_ff <= psc_ff;
      fy2_ff <= 34'(sp1_ff);
      cp2_ff <= 34'(cp1_ff);
      rx2_ff <= neg ? 34'(sy1_ff) : -34'(sy1_ff);
      rz2_ff <= neg ? -34'(cy1_ff) : 34'(cy1_ff);
      uy2_ff <= neg ? -34'(cp1_ff) : 34'(cp1_ff);
      ux2_ff <= neg ? pcs_ff : -pcs_ff;
      uz2_ff <= neg ? pss_ff : -pss_ff;
   end

   assign deg_in = (round_sat(ext(cp2_ff), S31) == '0);

   always_ff @(posedge clock) begin
      fx_ff  <= round_sat(fx2_ff, S62);
      fy_ff  <= round_sat(ext(fy2_ff), S31);
      fz_ff  <= round_sat(fz2_ff, S62);
      rx_ff  <= deg_in ? '0 : round_sat(ext(rx2_ff), S31);
      rz_ff  <= deg_in ? '0 : round_sat(ext(rz2_ff), S31);
      ux_ff  <= deg_in ? '0 : round_sat(ux2_ff, S62);
      uy_ff  <= deg_in ? '0 : round_sat(ext(uy2_ff), S31);
      uz_ff  <= deg_in ? '0 : round_sat(uz2_ff, S62);
      deg_ff <= deg_in;
   end

   assign front_x    = fx_ff;
   assign front_y    = fy_ff;
   assign front_z    = fz_ff;
   assign right_x    = rx_ff;
   assign right_y    = '0;
   assign right_z    = rz_ff;
   assign up_x       = ux_ff;
   assign up_y       = uy_ff;
   assign up_z       = uz_ff;
   assign degenerate = deg_ff;
endmodule

FILE: design/camera_basis_from_yaw_pitch.sv
// Top level: camera basis vectors from yaw and pitch, fully pipelined.
//
//   channel   strobe / ready     payload
//   request   start / busy       req_yaw_deg, req_pitch_deg
//   result    rsp_valid / -      rsp_front_*, rsp_right_*, rsp_up_*, rsp_degenerate
//
// One transfer per cycle; each request passes through the reduction stages, the seven
// three-stage Horner steps of the cosine series and the output stages to its result.
// busy is always low. Reset clears only the valid line; the data path holds no state.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module camera_basis_from_yaw_pitch #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int OUT_FRAC_BITS = 15
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [cbyp_pkg::IN_W-1:0]   req_yaw_deg,
   input  logic signed [cbyp_pkg::IN_W-1:0]   req_pitch_deg,
   output logic                               rsp_valid,
   output logic signed [OUT_FRAC_BITS:0]      rsp_front_x,
   output logic signed [OUT_FRAC_BITS:0]      rsp_front_y,
   output logic signed [OUT_FRAC_BITS:0]      rsp_front_z,
   output logic signed [OUT_FRAC_BITS:0]      rsp_right_x,
   output logic signed [OUT_FRAC_BITS:0]      rsp_right_y,
   output logic signed [OUT_FRAC_BITS:0]      rsp_right_z,
   output logic signed [OUT_FRAC_BITS:0]      rsp_up_x,
   output logic signed [OUT_FRAC_BITS:0]      rsp_up_y,
   output logic signed [OUT_FRAC_BITS:0]      rsp_up_z,
   output logic                               rsp_degenerate
);
`include "assert_macros.svh"

   localparam int LAT = cbyp_pkg::SC_LAT + cbyp_pkg::BASIS_LAT;

   logic [LAT-1:0] valid_ff, valid_in;
   cbyp_pkg::trig_type yaw_trig, pitch_trig;

   assign busy = 1'b0;
   assign valid_in = {valid_ff[LAT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   cbyp_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
      .clock(clock), .angle(req_yaw_deg), .trig(yaw_trig)
   );

   cbyp_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
      .clock(clock), .angle(req_pitch_deg), .trig(pitch_trig)
   );

   cbyp_basis #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_basis (
      .clock(clock),
      .yaw(yaw_trig),
      .pitch(pitch_trig),
      .front_x(rsp_front_x),
      .front_y(rsp_front_y),
      .front_z(rsp_front_z),
      .right_x(rsp_right_x),
      .right_y(rsp_right_y),
      .right_z(rsp_right_z),
      .up_x(rsp_up_x),
      .up_y(rsp_up_y),
      .up_z(rsp_up_z),
      .degenerate(rsp_degenerate)
   );

   assign rsp_valid = valid_ff[LAT-1];

   `ASSERT_DELAY(a_latency, clock, reset, start && !busy, LAT, rsp_valid)
   `ASSERT_IMPLIES(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate, rsp_right_x == 0 && rsp_right_z == 0 && rsp_up_x == 0 && rsp_up_y == 0 && rsp_up_z == 0)
   `ASSERT_IMPLIES(a_up_y_sign, clock, reset, rsp_valid && !rsp_degenerate, !rsp_up_y[OUT_FRAC_BITS])
endmodule

FILE: bench/cbyp_checker.sv
// Checker for the camera basis block: predicts each transfer and compares results.
`timescale 1ns / 1ps
module cbyp_checker #(
   parameter int ANGLE_FRAC_BITS = 7,
   parameter int OUT_FRAC_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic signed [16:0]            req_yaw_deg,
   input  logic signed [16:0]            req_pitch_deg,
   input  logic                          rsp_valid,
   input  logic signed [OUT_FRAC_BITS:0] rsp_front_x,
   input  logic signed [OUT_FRAC_BITS:0] rsp_front_y,
   input  logic signed [OUT_FRAC_BITS:0] rsp_front_z,
   input  logic signed [OUT_FRAC_BITS:0] rsp_right_x,
   input  logic signed [OUT_FRAC_BITS:0] rsp_right_y,
   input  logic signed [OUT_FRAC_BITS:0] rsp_right_z,
   input  logic signed [OUT_FRAC_BITS:0] rsp_up_x,
   input  logic signed [OUT_FRAC_BITS:0] rsp_up_y,
   input  logic signed [OUT_FRAC_BITS:0] rsp_up_z,
   input  logic                          rsp_degenerate,
   output int                            fail_count,
   output int                            pending
);
   localparam int OW = OUT_FRAC_BITS + 1;

   typedef struct {
      logic signed [OW-1:0] v [9];
      logic                 degen;
   } basis_type;

   basis_type basis_q[$];

   function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
      return (a * b + 64'h8000_0000) >> 32;
   endfunction

   // Taylor sin/cos on the first octant, Q32
   function automatic void octant_trig(input longint unsigned r,
                                       output longint unsigned sn,
                                       output longint unsigned cs);
      longint unsigned sdv [6] = '{156, 110, 72, 42, 20, 6};
      longint unsigned cdv [7] = '{182, 132, 90, 56, 30, 12, 2};
      longint unsigned r2, t, one;
      one = 64'h1_0000_0000;
      r2 = qmul(r, r);
      t = one;
      for (int i = 0; i < 6; i++) t = one - qmul(r2, t) / sdv[i];
      sn = qmul(r, t);
      t = one;
      for (int i = 0; i < 7; i++) t = one - qmul(r2, t) / cdv[i];
      cs = t;
   endfunction

   function automatic void angle_trig(input longint ang, output longint sn,
                                      output longint cs);
      longint quarter, full, eighth, q, rem, s1, c1;
      longint unsigned r, s0, c0, tmp;
      bit flip;
      quarter = 90 << ANGLE_FRAC_BITS;
      full = 4 * quarter;
      eighth = 45 << ANGLE_FRAC_BITS;
      ang = ang % full;
      if (ang < 0) ang += full;
      q = ang / quarter;
      rem = ang - q * quarter;
      flip = rem > eighth;
      if (flip) rem = quarter - rem;
      r = (longint'(rem) * 64'd19190098069 + (64'd1 << (ANGLE_FRAC_BITS + 7)))
          >> (ANGLE_FRAC_BITS + 8);
      octant_trig(r, s0, c0);
      if (flip) begin
         tmp = s0; s0 = c0; c0 = tmp;
      end
      s1 = longint'((s0 + 1) >> 1);
      c1 = longint'((c0 + 1) >> 1);
      case (q)
         0: begin sn = s1;  cs = c1;  end
         1: begin sn = c1;  cs = -s1; end
         2: begin sn = -s1; cs = -c1; end
         default: begin sn = -c1; cs = s1; end
      endcase
   endfunction

   function automatic longint rnd_sat(longint v, int sh);
      longint unsigned m, lim;
      bit neg;
      neg = v < 0;
      m = neg ? -v : v;
      m = (m + (64'd1 << (sh - 1))) >> sh;
      lim = 64'd1 << OUT_FRAC_BITS;
      if (neg) begin
         if (m > lim) m = lim;
         return -longint'(m);
      end
      if (m > lim - 1) m = lim - 1;
      return longint'(m);
   endfunction

   function automatic basis_type predict_basis(longint yaw, longint pitch);
      basis_type b;
      longint sy, cy, sp, cp, sg;
      int s31, s62;
      s31 = 31 - OUT_FRAC_BITS;
      s62 = 62 - OUT_FRAC_BITS;
      angle_trig(yaw, sy, cy);
      angle_trig(pitch, sp, cp);
      foreach (b.v[i]) b.v[i] = '0;
      b.v[0] = OW'(rnd_sat(cy * cp, s62));
      b.v[1] = OW'(rnd_sat(sp, s31));
      b.v[2] = OW'(rnd_sat(sy * cp, s62));
      b.degen = rnd_sat(cp, s31) == 0;
      if (!b.degen) begin
         sg = cp < 0 ? -1 : 1;
         b.v[3] = OW'(rnd_sat(-sg * sy, s31));
         b.v[5] = OW'(rnd_sat(sg * cy, s31));
         b.v[6] = OW'(rnd_sat(-sg * (cy * sp), s62));
         b.v[7] = OW'(rnd_sat(sg * cp, s31));
         b.v[8] = OW'(rnd_sat(-sg * (sy * sp), s62));
      end
      return b;
   endfunction

   string field_names [9] = '{"front_x", "front_y", "front_z", "right_x", "right_y",
                              "right_z", "up_x", "up_y", "up_z"};
   logic signed [OW-1:0] got [9];

   assign got = '{rsp_front_x, rsp_front_y, rsp_front_z, rsp_right_x, rsp_right_y,
                  rsp_right_z, rsp_up_x, rsp_up_y, rsp_up_z};

   always @(posedge clock) begin
      basis_type exp_b;
      if (!reset) begin
         if (start && !busy)
            basis_q.push_back(predict_basis(req_yaw_deg, req_pitch_deg));
         if (rsp_valid) begin
            if (basis_q.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count++;
            end else begin
               exp_b = basis_q.pop_front();
               for (int i = 0; i < 9; i++)
                  if (got[i] !== exp_b.v[i]) begin
                     $error("%s: expected %0d, got %0d", field_names[i], exp_b.v[i], got[i]);
                     fail_count++;
                  end
               if (rsp_degenerate !== exp_b.degen) begin
                  $error("degenerate: expected %0d, got %0d", exp_b.degen, rsp_degenerate);
                  fail_count++;
               end
            end
         end
      end
      pending <= basis_q.size();
   end
endmodule

FILE: bench/tb_camera_basis_from_yaw_pitch.sv
// Testbench top: stimulus for the camera basis block and the final verdict.
`timescale 1ns / 1ps
module tb_camera_basis_from_yaw_pitch;
   localparam int IW = cbyp_pkg::IN_W;
   localparam int ANG_MAX = 46080;
   localparam int LATENCY = 30;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [IW-1:0] req_yaw_deg = '0;
   logic signed [IW-1:0] req_pitch_deg = '0;
   logic rsp_valid, rsp_degenerate;
   logic signed [15:0] rsp_front_x, rsp_front_y, rsp_front_z;
   logic signed [15:0] rsp_right_x, rsp_right_y, rsp_right_z;
   logic signed [15:0] rsp_up_x, rsp_up_y, rsp_up_z;
   int fail_count, pending;
   int cycles = 0;
   int gap_pct = 0;

   camera_basis_from_yaw_pitch u_top (.*);

   cbyp_checker u_checker (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one transfer; idles at random before it
   task automatic send_angles(int yaw, int pitch);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_yaw_deg <= IW'(yaw);
      req_pitch_deg <= IW'(pitch);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic int rand_angle();
      case ($urandom_range(3))
         0: return $urandom_range(2 * ANG_MAX) - ANG_MAX;
         // near multiples of 45 degrees, where octant folds switch
         1: return 45 * 128 * ($urandom_range(16) - 8) + $urandom_range(6) - 3;
         // near multiples of 90 degrees, which include vertical pitch
         2: return 90 * 128 * ($urandom_range(8) - 4) + $urandom_range(4) - 2;
         default: return $urandom_range(512) - 256;
      endcase
   endfunction

   initial begin
      int dir [] = '{0, -ANG_MAX, ANG_MAX, 11520, -11520, 23040, 34560, 5760, 5761,
                     5759, 11519, 11521, 46079, -46079, 1, -1, 65535, -65536};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir[i]) send_angles(dir[i], dir[(i * 7 + 3) % dir.size()]);
      send_angles(0, 11520);
      send_angles(5760, -11520);
      send_angles(-5760, 34560);
      for (int ph = 0; ph < 3; ph++) begin
         gap_pct = ph == 0 ? 6 : (ph == 1 ? 71 : 0);
         repeat (500) send_angles(rand_angle(), rand_angle());
      end
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
